// File: hdl/spp_pkg.sv
// Shared types, constants and command/status structs for the steric pair penalty block.
package spp_pkg;

    localparam int DATA_W            = 32;
    localparam int TOTAL_W           = 48;
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int SQRT_STEPS        = 32;
    localparam int CFG_IDX_W         = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF    = 1'b1;

    localparam logic [DATA_W-1:0] MIN_DIST_RESET = 32'd131072;
    localparam logic [DATA_W-1:0] COEFF_RESET    = 32'd65536;

    // operand pairs for the shared 32x32 multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_DMIN2,
        MUL_SQX,
        MUL_SQY,
        MUL_SQZ,
        MUL_DSQ,
        MUL_ELO,
        MUL_EHI,
        MUL_K,
        MUL_GXL,
        MUL_GXH,
        MUL_GYL,
        MUL_GYH,
        MUL_GZL,
        MUL_GZH
    } mul_op_t;

    typedef struct packed {
        logic    load;       // capture a new transaction
        mul_op_t mul_op;     // multiplier operation issued this cycle
        logic    cmp;        // overlap test, root init
        logic    root_step;  // one square root digit
        logic    setup;      // diff and divider init
        logic    div_step;   // one quotient bit on all three lanes
        logic    div_first;  // first quotient bit
        logic    finish;     // load result register, update running sum
    } dp_cmd_t;

    typedef struct packed {
        logic hit;           // pair overlaps (valid during compare)
    } dp_stat_t;

endpackage

// File: hdl/spp_ctrl.sv
// Sequencer for the steric pair penalty: steps the datapath through one transaction.
module spp_ctrl
    import spp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    localparam int CNT_W     = $clog2(SQRT_STEPS);
    localparam int DIV_STEPS = FRAC_BITS + 1;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_PREP  = 9'b000000010,
        ST_CMP   = 9'b000000100,
        ST_ROOT  = 9'b000001000,
        ST_SETUP = 9'b000010000,
        ST_SCALE = 9'b000100000,
        ST_DIV   = 9'b001000000,
        ST_GRAD  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic              phase_reg, phase_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.mul_op     = MUL_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    phase_next = 1'b0;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (!phase_reg)
                begin
                    unique case (step_reg)
                        CNT_W'(0): cmd.mul_op = MUL_DMIN2;
                        CNT_W'(1): cmd.mul_op = MUL_SQX;
                        CNT_W'(2): cmd.mul_op = MUL_SQY;
                        default:   cmd.mul_op = MUL_SQZ;
                    endcase
                end
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    step_next = step_reg + 1'b1;
                    if (step_reg == CNT_W'(3))
                    begin
                        step_next  = '0;
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                cmd.cmp    = 1'b1;
                step_next  = '0;
                state_next = stat.hit ? ST_ROOT : ST_DONE;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                phase_next = 1'b0;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (!phase_reg)
                begin
                    unique case (step_reg)
                        CNT_W'(0): cmd.mul_op = MUL_DSQ;
                        CNT_W'(1): cmd.mul_op = MUL_ELO;
                        CNT_W'(2): cmd.mul_op = MUL_EHI;
                        default:   cmd.mul_op = MUL_K;
                    endcase
                end
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    step_next = step_reg + 1'b1;
                    if (step_reg == CNT_W'(3))
                    begin
                        step_next  = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (step_reg == '0);
                step_next     = step_reg + 1'b1;
                if (step_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    phase_next = 1'b0;
                    state_next = ST_GRAD;
                end
            end
            ST_GRAD:
            begin
                if (!phase_reg)
                begin
                    unique case (step_reg)
                        CNT_W'(0): cmd.mul_op = MUL_GXL;
                        CNT_W'(1): cmd.mul_op = MUL_GXH;
                        CNT_W'(2): cmd.mul_op = MUL_GYL;
                        CNT_W'(3): cmd.mul_op = MUL_GYH;
                        CNT_W'(4): cmd.mul_op = MUL_GZL;
                        default:   cmd.mul_op = MUL_GZH;
                    endcase
                end
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    step_next = step_reg + 1'b1;
                    if (step_reg == CNT_W'(5))
                    begin
                        step_next  = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: hdl/spp_datapath.sv
// Datapath: config registers, shared multiplier, square root, dividers, result register.
module spp_datapath
    import spp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]           cfg_data,
    input  logic signed [DATA_W-1:0]    first_x,
    input  logic signed [DATA_W-1:0]    first_y,
    input  logic signed [DATA_W-1:0]    first_z,
    input  logic signed [DATA_W-1:0]    second_x,
    input  logic signed [DATA_W-1:0]    second_y,
    input  logic signed [DATA_W-1:0]    second_z,
    input  logic                        last_pair,
    input  dp_cmd_t                     cmd,
    output dp_stat_t                    stat,
    output logic                        overlap,
    output logic [DATA_W-1:0]           pair_energy,
    output logic signed [DATA_W-1:0]    grad_x,
    output logic signed [DATA_W-1:0]    grad_y,
    output logic signed [DATA_W-1:0]    grad_z,
    output logic [TOTAL_W-1:0]          energy_total,
    output logic                        last_out
);

    localparam int U_W = FRAC_BITS + 1;

    logic [DATA_W-1:0]   dmin_reg, coeff_reg;
    logic [TOTAL_W-1:0]  sum_reg;

    logic [DATA_W-1:0]   ax_reg, ay_reg, az_reg;
    logic [2:0]          neg_reg, nz_reg;
    logic                last_reg, range_ok_reg, hit_reg, dzero_reg;

    logic [63:0]         prod_reg, dmin2_reg, dsq_reg, lo_reg, k_reg, src_reg;
    mul_op_t             op_d_reg;
    logic [65:0]         acc_reg;
    logic [32:0]         rem_reg;
    logic [DATA_W-1:0]   root_reg, diff_reg, energy_reg;
    logic [DATA_W-1:0]   divr_reg [3];
    logic [U_W-1:0]      u_reg [3];
    logic [DATA_W-1:0]   g_reg [3];

    logic                ovl_out_reg, last_out_reg;
    logic [DATA_W-1:0]   energy_out_reg;
    logic [DATA_W-1:0]   g_out_reg [3];
    logic [TOTAL_W-1:0]  total_out_reg;

    logic signed [32:0]  dx, dy, dz;
    logic [32:0]         mx, my, mz;
    logic [DATA_W-1:0]   mul_a, mul_b;
    logic [95:0]         wide;
    logic [34:0]         sq_r2, sq_trial;
    logic [TOTAL_W:0]    sum_add;
    logic [TOTAL_W-1:0]  sum_sat;

    // signed gradient for one axis: (w >> FRAC_BITS), negated unless neg, clamped
    function automatic logic [DATA_W-1:0] grad_sat(input logic [95:0] w, input logic neg,
                                                   input logic nz, input logic dz0);
        logic [95:0] m;
        m = w >> FRAC_BITS;
        if (!nz || dz0)
            grad_sat = '0;
        else if (!neg)
            grad_sat = (m > 96'h8000_0000) ? 32'h8000_0000 : (32'd0 - m[DATA_W-1:0]);
        else
            grad_sat = (m > 96'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[DATA_W-1:0];
    endfunction

    // configuration and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dmin_reg  <= MIN_DIST_RESET;
            coeff_reg <= COEFF_RESET;
            sum_reg   <= '0;
            op_d_reg  <= MUL_NONE;
        end
        else
        begin
            op_d_reg <= cmd.mul_op;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_MIN_DIST: dmin_reg  <= cfg_data;
                    REG_COEFF:    coeff_reg <= cfg_data;
                    default:      dmin_reg  <= dmin_reg;
                endcase
            end
            if (cmd.finish)
                sum_reg <= last_reg ? '0 : sum_sat;
        end
    end

    assign dx = 33'(first_x) - 33'(second_x);
    assign dy = 33'(first_y) - 33'(second_y);
    assign dz = 33'(first_z) - 33'(second_z);
    assign mx = dx[32] ? 33'(-dx) : 33'(dx);
    assign my = dy[32] ? 33'(-dy) : 33'(dy);
    assign mz = dz[32] ? 33'(-dz) : 33'(dz);

    always_comb
    begin
        unique case (cmd.mul_op)
            MUL_DMIN2: begin mul_a = dmin_reg;         mul_b = dmin_reg;  end
            MUL_SQX:   begin mul_a = ax_reg;           mul_b = ax_reg;    end
            MUL_SQY:   begin mul_a = ay_reg;           mul_b = ay_reg;    end
            MUL_SQZ:   begin mul_a = az_reg;           mul_b = az_reg;    end
            MUL_DSQ:   begin mul_a = diff_reg;         mul_b = diff_reg;  end
            MUL_ELO:   begin mul_a = dsq_reg[31:0];    mul_b = coeff_reg; end
            MUL_EHI:   begin mul_a = dsq_reg[63:32];   mul_b = coeff_reg; end
            MUL_K:     begin mul_a = coeff_reg;        mul_b = diff_reg;  end
            MUL_GXL:   begin mul_a = k_reg[31:0];      mul_b = 32'(u_reg[0]); end
            MUL_GXH:   begin mul_a = k_reg[63:32];     mul_b = 32'(u_reg[0]); end
            MUL_GYL:   begin mul_a = k_reg[31:0];      mul_b = 32'(u_reg[1]); end
            MUL_GYH:   begin mul_a = k_reg[63:32];     mul_b = 32'(u_reg[1]); end
            MUL_GZL:   begin mul_a = k_reg[31:0];      mul_b = 32'(u_reg[2]); end
            MUL_GZH:   begin mul_a = k_reg[63:32];     mul_b = 32'(u_reg[2]); end
            default:   begin mul_a = '0;               mul_b = '0;        end
        endcase
    end

    // high partial product joined with the stored low one
    assign wide     = {prod_reg, 32'd0} + {32'd0, lo_reg};
    assign sq_r2    = {rem_reg, src_reg[63:62]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sum_add  = {1'b0, sum_reg} + (TOTAL_W + 1)'(energy_reg);
    assign sum_sat  = sum_add[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_add[TOTAL_W-1:0];

    assign stat.hit = range_ok_reg && (acc_reg < {2'b00, dmin2_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.mul_op != MUL_NONE)
            prod_reg <= 64'(mul_a) * 64'(mul_b);

        if (cmd.load)
        begin
            ax_reg       <= mx[31:0];
            ay_reg       <= my[31:0];
            az_reg       <= mz[31:0];
            neg_reg      <= {dz[32], dy[32], dx[32]};
            nz_reg       <= {dz != '0, dy != '0, dx != '0};
            last_reg     <= last_pair;
            range_ok_reg <= (mx < 33'(dmin_reg)) && (my < 33'(dmin_reg))
                            && (mz < 33'(dmin_reg));
            hit_reg      <= 1'b0;
            energy_reg   <= '0;
            for (int i = 0; i < 3; i++)
                g_reg[i] <= '0;
        end

        unique case (op_d_reg)
            MUL_DMIN2: dmin2_reg <= prod_reg;
            MUL_SQX:   acc_reg   <= {2'b00, prod_reg};
            MUL_SQY,
            MUL_SQZ:   acc_reg   <= acc_reg + {2'b00, prod_reg};
            MUL_DSQ:   dsq_reg   <= prod_reg;
            MUL_ELO,
            MUL_GXL,
            MUL_GYL,
            MUL_GZL:   lo_reg    <= prod_reg;
            MUL_EHI:   energy_reg <= ((wide >> (2 * FRAC_BITS)) > 96'hFFFF_FFFF)
                                     ? 32'hFFFF_FFFF : wide[2*FRAC_BITS +: DATA_W];
            MUL_K:     k_reg     <= prod_reg >> (FRAC_BITS - 1);
            MUL_GXH:   g_reg[0]  <= grad_sat(wide, neg_reg[0], nz_reg[0], dzero_reg);
            MUL_GYH:   g_reg[1]  <= grad_sat(wide, neg_reg[1], nz_reg[1], dzero_reg);
            MUL_GZH:   g_reg[2]  <= grad_sat(wide, neg_reg[2], nz_reg[2], dzero_reg);
            default:   ;
        endcase

        if (cmd.cmp)
        begin
            hit_reg  <= stat.hit;
            src_reg  <= acc_reg[63:0];
            rem_reg  <= '0;
            root_reg <= '0;
        end

        // restoring square root, one result bit per cycle
        if (cmd.root_step)
        begin
            src_reg <= {src_reg[61:0], 2'b00};
            if (sq_r2 >= sq_trial)
            begin
                rem_reg  <= 33'(sq_r2 - sq_trial);
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= sq_r2[32:0];
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end

        if (cmd.setup)
        begin
            diff_reg    <= dmin_reg - root_reg;
            dzero_reg   <= (root_reg == '0);
            divr_reg[0] <= {1'b0, ax_reg[31:1]};
            divr_reg[1] <= {1'b0, ay_reg[31:1]};
            divr_reg[2] <= {1'b0, az_reg[31:1]};
            for (int i = 0; i < 3; i++)
                u_reg[i] <= '0;
        end

        // (|delta| << F) / d, three lanes, one quotient bit per cycle
        if (cmd.div_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic [32:0] r2;
                logic        bin;
                unique case (i)
                    0:       bin = ax_reg[0];
                    1:       bin = ay_reg[0];
                    default: bin = az_reg[0];
                endcase
                r2 = {divr_reg[i], cmd.div_first & bin};
                if (r2 >= {1'b0, root_reg})
                begin
                    divr_reg[i] <= 32'(r2 - {1'b0, root_reg});
                    u_reg[i]    <= {u_reg[i][U_W-2:0], 1'b1};
                end
                else
                begin
                    divr_reg[i] <= r2[31:0];
                    u_reg[i]    <= {u_reg[i][U_W-2:0], 1'b0};
                end
            end
        end

        if (cmd.finish)
        begin
            ovl_out_reg    <= hit_reg;
            energy_out_reg <= energy_reg;
            for (int i = 0; i < 3; i++)
                g_out_reg[i] <= g_reg[i];
            total_out_reg  <= sum_sat;
            last_out_reg   <= last_reg;
        end
    end

    assign overlap      = ovl_out_reg;
    assign pair_energy  = energy_out_reg;
    assign grad_x       = g_out_reg[0];
    assign grad_y       = g_out_reg[1];
    assign grad_z       = g_out_reg[2];
    assign energy_total = total_out_reg;
    assign last_out     = last_out_reg;

endmodule

// File: hdl/steric_pair_penalty.sv
// Top level of the steric pair penalty block: sequencer plus datapath.
//
// Harmonic soft-sphere repulsion for one atom pair per transaction.
// Input channel (in_valid/in_stall) carries the two Q.FRAC_BITS positions
// and a last_pair mark; output channel (out_valid/out_stall) returns overlap,
// pair energy, gradient for the first atom and the running energy total.
// One transaction is worked at a time. A pair that does not overlap goes
// from the overlap test straight to the final step; for one that does,
// the work is set by the 32-step restoring square root, the FRAC_BITS+1
// step division by the distance, and the single shared 32x32 multiplier
// that forms the partial products one after another. The next transaction
// is taken once the block has returned to idle. A result waiting in the
// output register does not block the next transaction from being worked;
// the block only holds in its final step until the output register is
// free. Reset (rst_n, async, active low) restores min_distance and
// energy_coeff to their defaults and clears the running sum; the sum also
// clears after a result marked last_out. The user keeps config writes
// (cfg_wr_en) to idle; the block itself does not enforce it.
module steric_pair_penalty
    import spp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]           cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [DATA_W-1:0]    first_x,
    input  logic signed [DATA_W-1:0]    first_y,
    input  logic signed [DATA_W-1:0]    first_z,
    input  logic signed [DATA_W-1:0]    second_x,
    input  logic signed [DATA_W-1:0]    second_y,
    input  logic signed [DATA_W-1:0]    second_z,
    input  logic                        last_pair,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        overlap,
    output logic [DATA_W-1:0]           pair_energy,
    output logic signed [DATA_W-1:0]    grad_x,
    output logic signed [DATA_W-1:0]    grad_y,
    output logic signed [DATA_W-1:0]    grad_z,
    output logic [TOTAL_W-1:0]          energy_total,
    output logic                        last_out
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    spp_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    spp_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .first_x      (first_x),
        .first_y      (first_y),
        .first_z      (first_z),
        .second_x     (second_x),
        .second_y     (second_y),
        .second_z     (second_z),
        .last_pair    (last_pair),
        .cmd          (cmd),
        .stat         (stat),
        .overlap      (overlap),
        .pair_energy  (pair_energy),
        .grad_x       (grad_x),
        .grad_y       (grad_y),
        .grad_z       (grad_z),
        .energy_total (energy_total),
        .last_out     (last_out)
    );

    // a freshly accepted transaction keeps the input side busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after transaction accepted");

    // a pair that does not overlap carries no energy and no gradient
    a_no_overlap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overlap |-> pair_energy == '0 && grad_x == '0
                                  && grad_y == '0 && grad_z == '0)
        else $error("non-overlapping pair with nonzero result");

    // running total always covers the current pair
    a_total_covers_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> energy_total >= TOTAL_W'(pair_energy))
        else $error("running total below pair energy");

endmodule

// File: bench/testbench.sv
// Self-checking bench for the steric pair penalty block.
`timescale 1ns / 100ps

module testbench;
    import spp_pkg::*;

    localparam int FB        = 16;
    localparam int NUM_RAND  = 1830;
    localparam int MAX_CYC   = 1500000;
    localparam int MAX_ERR_SHOWN = 10;

    // One pair result as the block reports it.
    typedef struct {
        logic                      hit;
        logic [DATA_W-1:0]         energy;
        logic [DATA_W-1:0]         gx;
        logic [DATA_W-1:0]         gy;
        logic [DATA_W-1:0]         gz;
        logic [TOTAL_W-1:0]        total;
        logic                      last;
    } penalty_t;

    // Penalty predictor plus queue of pending penalty results.
    class penalty_board;
        logic [31:0] dmin;
        logic [31:0] coeff;
        logic [47:0] run_sum;
        penalty_t    pending[$];
        int          mismatches;
        int          matched;

        function new();
            dmin = MIN_DIST_RESET;
            coeff = COEFF_RESET;
            run_sum = '0;
            mismatches = 0;
            matched = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            if (idx == REG_MIN_DIST)
                dmin = val;
            else
                coeff = val;
        endfunction

        static function logic [31:0] axis_grad(logic signed [63:0] delta,
                                               logic [127:0] k, logic [63:0] d);
            logic [127:0] mag;
            logic [127:0] u;
            logic [127:0] m;
            if (delta == 0 || d == 0)
                return '0;
            mag = (delta < 0) ? -delta : delta;
            u = (mag << FB) / d;
            m = (k * u) >> FB;
            if (delta > 0)
            begin
                if (m > 128'h8000_0000)
                    m = 128'h8000_0000;
                return -m[31:0];
            end
            if (m > 128'h7FFF_FFFF)
                m = 128'h7FFF_FFFF;
            return m[31:0];
        endfunction

        // Predict one pair transaction.
        function void note_pair(logic signed [31:0] ax, ay, az, bx, by, bz, logic lst);
            logic signed [63:0] dx, dy, dz;
            logic [63:0]  mx, my, mz;
            logic [127:0] dsq, diff, e, k, lim;
            logic [63:0]  root;
            penalty_t     r;
            dx = 64'(ax) - 64'(bx);
            dy = 64'(ay) - 64'(by);
            dz = 64'(az) - 64'(bz);
            mx = dx < 0 ? -dx : dx;
            my = dy < 0 ? -dy : dy;
            mz = dz < 0 ? -dz : dz;
            r.hit = 0; r.energy = 0; r.gx = 0; r.gy = 0; r.gz = 0;
            if (mx < dmin && my < dmin && mz < dmin)
            begin
                dsq = 128'(mx) * mx + 128'(my) * my + 128'(mz) * mz;
                lim = 128'(dmin) * dmin;
                if (dsq < lim && dsq[127:64] == 0)
                begin
                    root = 0;
                    for (int b = 31; b >= 0; b--)
                        if (128'(root | (64'd1 << b)) * (root | (64'd1 << b)) <= dsq)
                            root |= 64'd1 << b;
                    diff = dmin - root;
                    r.hit = 1;
                    e = (diff * diff * coeff) >> (2 * FB);
                    r.energy = (e > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
                    k = (128'(coeff) * diff) >> (FB - 1);
                    r.gx = axis_grad(dx, k, root);
                    r.gy = axis_grad(dy, k, root);
                    r.gz = axis_grad(dz, k, root);
                end
            end
            e = 128'(run_sum) + r.energy;
            run_sum = (e > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : e[47:0];
            r.total = run_sum;
            r.last = lst;
            if (lst)
                run_sum = '0;
            pending.push_back(r);
        endfunction

        function void check_result(penalty_t got);
            penalty_t w;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_ERR_SHOWN)
                    $display("ERROR: unexpected result at %0t", $time);
                return;
            end
            w = pending.pop_front();
            if (got.hit !== w.hit || got.energy !== w.energy || got.gx !== w.gx ||
                got.gy !== w.gy || got.gz !== w.gz || got.total !== w.total ||
                got.last !== w.last)
            begin
                mismatches++;
                if (mismatches <= MAX_ERR_SHOWN)
                    $display("ERROR %0t: exp ov=%0b e=%h g=%h %h %h t=%h l=%0b got ov=%0b e=%h g=%h %h %h t=%h l=%0b",
                        $time, w.hit, w.energy, w.gx, w.gy, w.gz, w.total, w.last,
                        got.hit, got.energy, got.gx, got.gy, got.gz, got.total, got.last);
            end
            else
                matched++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [DATA_W-1:0] first_x = 0, first_y = 0, first_z = 0;
    logic signed [DATA_W-1:0] second_x = 0, second_y = 0, second_z = 0;
    logic last_pair = 0;
    logic out_valid;
    logic out_stall = 0;
    logic overlap;
    logic [DATA_W-1:0] pair_energy;
    logic signed [DATA_W-1:0] grad_x, grad_y, grad_z;
    logic [TOTAL_W-1:0] energy_total;
    logic last_out;

    penalty_board board = new();
    bit  calm_phase = 0;     // no idling on either side
    bit  hold_output = 0;    // long receiver hold-off request
    int  cycle_count = 0;

    always #1 clk = ~clk;

    steric_pair_penalty #(.FRAC_BITS(FB)) uut (.*);

    // Watchdog: ends the run if the block locks up.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYC)
        begin
            $display("FAIL steric_pair_penalty");
            $finish;
        end
    end

    // Sample outputs at the rising edge: a result transaction happens when
    // out_valid is high and we are not stalling.
    always @(posedge clk)
    begin
        penalty_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.hit = overlap; got.energy = pair_energy;
            got.gx = grad_x; got.gy = grad_y; got.gz = grad_z;
            got.total = energy_total; got.last = last_out;
            board.check_result(got);
        end
    end

    // Receiver stall: random bursts, or a long hold-off on request.
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                out_stall <= 1;
                repeat (400) @(negedge clk);
                hold_output = 0;
                out_stall <= 0;
            end
            else if (!calm_phase && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 5);
                out_stall <= 1;
                repeat (n) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    // Write a register while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 0;
        board.set_reg(idx, val);
        @(negedge clk);
    endtask

    // Offer one pair and hold it until the block takes it.
    // in_valid stays up after acceptance until an idle gap or a drain
    // takes it down.
    task automatic send_pair(logic [31:0] ax, ay, az, bx, by, bz, logic lst);
        if (!calm_phase && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        first_x <= ax; first_y <= ay; first_z <= az;
        second_x <= bx; second_y <= by; second_z <= bz;
        last_pair <= lst;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        board.note_pair(ax, ay, az, bx, by, bz, lst);
        @(negedge clk);
    endtask

    // Wait out all pending results and the block's worst-case latency.
    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    // Random pair near the minimum distance, so most overlap, with
    // occasional full-range noise.
    task automatic random_pair(logic [31:0] dm);
        logic [31:0] bx, by, bz, span;
        bx = $urandom; by = $urandom; bz = $urandom;
        span = (dm == 0) ? 32'd16 : dm;
        if ($urandom_range(0, 9) == 0)
            send_pair($urandom, $urandom, $urandom, bx, by, bz, $urandom_range(0, 7) == 0);
        else
            send_pair(bx + $urandom_range(0, span) - span / 2,
                      by + $urandom_range(0, span) - span / 2,
                      bz + $urandom_range(0, span) - span / 2,
                      bx, by, bz, $urandom_range(0, 7) == 0);
    endtask

    initial
    begin
        logic [31:0] dmins[6];
        logic [31:0] coeffs[6];
        int per_phase;
        repeat (4) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: reset settings, coincident atoms, each axis sign, far apart.
        send_pair(0, 0, 0, 0, 0, 0, 0);
        send_pair(32'h8000, 0, 0, 0, 0, 0, 0);
        send_pair(0, 32'h8000, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 0, 0, 32'h8000, 0);
        send_pair(32'h1000, 32'hFFFF_F000, 32'h3000, 0, 0, 0, 0);
        send_pair(32'h2_0000, 0, 0, 0, 0, 0, 0);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1);
        send_pair(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 1);
        drain();

        // Zero minimum distance: nothing overlaps.
        write_reg(REG_MIN_DIST, 0);
        send_pair(0, 0, 0, 0, 0, 0, 0);
        send_pair(1, 0, 0, 0, 0, 0, 1);
        drain();

        // Huge distance and coefficient: energy and gradient saturate, and the
        // sum adds up saturated pair energies, far below its 48-bit ceiling.
        write_reg(REG_MIN_DIST, 32'hFFFF_FFFF);
        write_reg(REG_COEFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++)
            send_pair(32'h4000_0000 + i, 32'h1234_0000, 0, 0, 32'h1234_0000, i, i == 7);
        send_pair(0, 0, 0, 0, 0, 0, 0);
        send_pair(32'h7FFF_0000, 32'h0, 32'h0, 32'h0, 32'h7FFF_0000, 32'h7FFF_0000, 0);
        drain();

        // Block fills up while the receiver holds off.
        hold_output = 1;
        for (int i = 0; i < 6; i++)
            random_pair(board.dmin);
        drain();

        // Random phases over a range of settings.
        dmins  = '{32'h2_0000, 32'h1, 32'h100_0000, 32'hFFFF_FFFF, 32'h8000, 32'h7FFF_FFFF};
        coeffs = '{32'h1_0000, 32'h0, 32'hFFFF_FFFF, 32'h10, 32'h8000_0000, 32'h3_2000};
        per_phase = NUM_RAND / 6;
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_MIN_DIST, dmins[p]);
            write_reg(REG_COEFF, p == 5 ? $urandom : coeffs[p]);
            if (p == 5)
                calm_phase = 1;
            for (int i = 0; i < per_phase; i++)
                random_pair(board.dmin);
            drain();
        end

        $display("Covered %0d checked pair results over several distance/coefficient settings,",
                 board.matched);
        $display("including zero distance, saturation, and a long output hold-off.");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("PASS steric_pair_penalty");
        else
            $display("FAIL steric_pair_penalty");
        $finish;
    end
endmodule

// File: files.f
hdl/spp_pkg.sv
hdl/spp_ctrl.sv
hdl/spp_datapath.sv
hdl/steric_pair_penalty.sv
bench/testbench.sv
